>>> rtl/id_keyed_slot_pool_assert.svh
// Assertion macros used by the slot pool datapath.
`ifndef ID_KEYED_SLOT_POOL_ASSERT_SVH
`define ID_KEYED_SLOT_POOL_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define IDKSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot pool assertion failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define IDKSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot pool assertion failed");

`endif

>>> rtl/idksp_pkg.sv
// Types and codes shared by the slot pool controller, datapath and top level.
package idksp_pkg;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ZERO_ID   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    create;
    logic    scan;
    logic    hit;
    logic    move_rd;
    logic    move_wr;
    logic    set_res;
    status_t res_code;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  id_zero;
    logic  full;
    logic  hit;
    logic  miss;
    logic  out_free;
  } stat_t;

endpackage

>>> rtl/idksp_ctrl.sv
// Controller state machine that sequences create, search and swap-remove.
module idksp_ctrl
  import idksp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (stat.kind)
          KIND_DELETE, KIND_LOOKUP: begin
            state_nxt = stat.id_zero ? S_FINISH : S_SCAN;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = (stat.kind == KIND_DELETE) ? S_MOVE_RD : S_FINISH;
        end else if (stat.miss) begin
          state_nxt = S_FINISH;
        end
      end
      S_MOVE_RD: state_nxt = S_MOVE_WR;
      S_MOVE_WR: state_nxt = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_OK;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_CHECK: begin
        case (stat.kind)
          KIND_CREATE: begin
            if (stat.full) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_FULL;
            end else begin
              cmd.create = 1'b1;
            end
          end
          KIND_DELETE, KIND_LOOKUP: begin
            if (stat.id_zero) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_ZERO_ID;
            end
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.hit = 1'b1;
        end else if (stat.miss) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MOVE_RD: cmd.move_rd = 1'b1;
      S_MOVE_WR: cmd.move_wr = 1'b1;
      S_FINISH:  cmd.publish = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/idksp_dp.sv
// Datapath: slot table memory, counters, scan pipeline and output register.
module idksp_dp
  import idksp_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_entry_id,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_new_id,
  output logic [5:0]  out_slot,
  output logic [6:0]  out_live
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  logic [31:0]   mem [MAX_ENTRIES];
  logic [CW-1:0] count_r;
  logic [31:0]   next_id_r;
  logic [31:0]   next_id_inc;
  logic [6:0]    cap_r;
  kind_t         kind_r;
  logic [31:0]   id_r;
  logic [CW-1:0] idx_r;
  logic          rd_valid_r;
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr_r;
  status_t       res_status_r;
  logic [31:0]   res_new_r;
  logic [AW-1:0] res_slot_r;
  logic          out_valid_r;
  status_t       out_status_r;
  logic [31:0]   out_new_r;
  logic [5:0]    out_slot_r;
  logic [6:0]    out_live_r;

  logic          idx_lt;
  logic          hit;
  logic          full;
  logic [CW-1:0] last_c;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  assign idx_lt      = idx_r < count_r;
  assign hit         = rd_valid_r && (rd_data_r == id_r);
  assign full        = (LW'(count_r) >= LW'(cap_r)) || (count_r == CW'(MAX_ENTRIES));
  assign last_c      = count_r - CW'(1);
  assign next_id_inc = next_id_r + 32'd1;

  assign stat.kind     = kind_r;
  assign stat.id_zero  = (id_r == 32'd0);
  assign stat.full     = full;
  assign stat.hit      = hit;
  assign stat.miss     = !rd_valid_r && !idx_lt;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    mem_we = cmd.create || cmd.move_wr;
    mem_wa = cmd.create ? count_r[AW-1:0] : res_slot_r;
    mem_wd = cmd.create ? next_id_r : rd_data_r;
    mem_re = (cmd.scan && idx_lt) || cmd.move_rd;
    mem_ra = cmd.move_rd ? last_c[AW-1:0] : idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
      rd_addr_r <= mem_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_id_r   <= 32'd1;
      cap_r       <= 7'd64;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.create) begin
        count_r   <= count_r + CW'(1);
        next_id_r <= (next_id_inc == 32'd0) ? 32'd1 : next_id_inc;
      end else if (cmd.move_wr) begin
        count_r <= last_c;
      end
      rd_valid_r <= cmd.scan && idx_lt;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind_t'(in_kind);
      id_r   <= in_entry_id;
      idx_r  <= '0;
    end else if (cmd.scan && idx_lt) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.create) begin
      res_status_r <= ST_OK;
      res_new_r    <= next_id_r;
      res_slot_r   <= count_r[AW-1:0];
    end else if (cmd.hit) begin
      res_status_r <= ST_OK;
      res_new_r    <= 32'd0;
      res_slot_r   <= rd_addr_r;
    end else if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_new_r    <= 32'd0;
      res_slot_r   <= '0;
    end
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_new_r    <= res_new_r;
      out_slot_r   <= 6'(res_slot_r);
      out_live_r   <= 7'(count_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_new_id = out_new_r;
  assign out_slot   = out_slot_r;
  assign out_live   = out_live_r;

  `include "id_keyed_slot_pool_assert.svh"

  `IDKSP_ASSERT_NOW(a_create_not_full, cmd.create, !full)
  `IDKSP_ASSERT_NOW(a_hit_in_table, cmd.hit, CW'(rd_addr_r) < count_r)
  `IDKSP_ASSERT_NOW(a_publish_free, cmd.publish, !out_valid_r || out_ready)
  `IDKSP_ASSERT_NEXT(a_remove_shrinks, cmd.move_wr, count_r == $past(count_r) - CW'(1))

endmodule

>>> rtl/id_keyed_slot_pool.sv
// Slot pool with swap-on-delete: a create goes from acceptance through the check and finish
// states to a result; a lookup's search time grows with the live entry count, and a delete
// takes longer, because the search reads the id table one slot per cycle and a delete then
// reads the last slot and writes it into the freed one. One transaction is worked on at a
// time; the next is accepted while the previous result waits in the output register.
module id_keyed_slot_pool
  import idksp_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [31:0] entry_id
  input  logic [1:0]  in_tuser,  // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // [31:0] new_id, [37:32] slot_index, [44:38] live_count
  output logic [1:0]  out_tuser, // [1:0] status
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  cmd_t        cmd;
  stat_t       stat;
  logic [1:0]  out_status;
  logic [31:0] out_new_id;
  logic [5:0]  out_slot;
  logic [6:0]  out_live;

  idksp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  idksp_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (in_tuser),
    .in_entry_id (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_status),
    .out_new_id  (out_new_id),
    .out_slot    (out_slot),
    .out_live    (out_live)
  );

  assign out_tdata = {3'b000, out_live, out_slot, out_new_id};
  assign out_tuser = out_status;

endmodule
